// File: sv/tfs_pkg.sv
// Package for the telemetry frame serializer: frame constants and the cell type.
// No dependencies; used by every module of the block.
package tfs_pkg;

  localparam logic [7:0] SyncDollar = 8'h24;
  localparam logic [7:0] SyncT      = 8'h54;
  localparam logic [7:0] IdAtt      = 8'h41;
  localparam logic [7:0] IdPos      = 8'h47;
  localparam logic [1:0] FixMask    = 2'b11;

  localparam int FrameALen = 10;
  localparam int FrameGLen = 18;
  // one extra cell lets a new frame load behind a stalled head byte
  localparam int ChainLen  = FrameGLen + 1;

  localparam int SlotW = 4;
  localparam logic [SlotW-1:0] SlotFirst = 4'd1;
  localparam logic [SlotW-1:0] SlotLast  = 4'd9;

  // one byte of the frame as held in a chain cell
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       att;
    logic       last;
  } cell_t;

endpackage

// File: sv/telemetry_frame_serializer.sv
// Telemetry frame serializer: one frame request in, one frame out a byte per beat.
// Depends on tfs_pkg, tfs_frame_build and tfs_cell.
//
// Each accepted request becomes a full frame loaded at once into a row of 19
// byte cells that shift toward the output, one byte per cycle while the output
// is not stalled. Slot 1 of a 1..9 schedule gives a 10-byte attitude frame,
// the other slots an 18-byte position frame ending in an XOR checksum. A new
// request is taken as soon as no more than the head byte of the previous frame
// remains in the chain, so back-to-back frames leave the output with no gap.
module telemetry_frame_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] latitude_i,
  input  logic signed [31:0] longitude_i,
  input  logic        [7:0]  ground_speed_i,
  input  logic signed [31:0] altitude_i,
  input  logic        [5:0]  satellite_count_i,
  input  logic        [1:0]  fix_kind_i,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] roll_angle_i,
  input  logic        [15:0] heading_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [7:0]  out_byte_o,
  output logic               is_attitude_o,
  output logic               frame_end_o
);

  localparam int N = tfs_pkg::ChainLen;
  localparam int F = tfs_pkg::FrameGLen;

  logic [tfs_pkg::SlotW-1:0] slot_d, slot_q;
  logic                      att;
  logic                      advance;
  logic                      accept;
  logic [N-1:0]              valid_vec;
  tfs_pkg::cell_t            frame [F];
  tfs_pkg::cell_t            cells [N];

  assign att     = (slot_q == tfs_pkg::SlotFirst);
  assign advance = !cells[0].valid || !out_stall_i;
  assign accept  = in_valid_i && !in_stall_o;
  // take a request once at most the head byte is left
  assign in_stall_o = cells[1].valid;

  // advance the frame schedule per request
  always_comb begin
    slot_d = slot_q;
    if (accept) begin
      slot_d = (slot_q >= tfs_pkg::SlotLast) ? tfs_pkg::SlotFirst
                                             : slot_q + tfs_pkg::SlotW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= tfs_pkg::SlotFirst;
    end else begin
      slot_q <= slot_d;
    end
  end

  tfs_frame_build u_build (
    .att_i             (att),
    .latitude_i        (latitude_i),
    .longitude_i       (longitude_i),
    .ground_speed_i    (ground_speed_i),
    .altitude_i        (altitude_i),
    .satellite_count_i (satellite_count_i),
    .fix_kind_i        (fix_kind_i),
    .pitch_angle_i     (pitch_angle_i),
    .roll_angle_i      (roll_angle_i),
    .heading_angle_i   (heading_angle_i),
    .frame_o           (frame)
  );

  // build the chain; a held head byte shifts the load one cell back
  for (genvar i = 0; i < N; i++) begin : g_cell
    tfs_pkg::cell_t load_val;
    tfs_pkg::cell_t nxt;
    logic           load;

    if (i == 0) begin : g_head
      assign load_val = frame[0];
      assign load     = accept && advance;
    end else if (i == N - 1) begin : g_tail
      assign load_val = advance ? tfs_pkg::cell_t'('0) : frame[i-1];
      assign load     = accept;
    end else begin : g_mid
      assign load_val = advance ? frame[i] : frame[i-1];
      assign load     = accept;
    end

    if (i == N - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_link
      assign nxt = cells[i+1];
    end

    tfs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (advance),
      .load_i     (load),
      .load_val_i (load_val),
      .nxt_i      (nxt),
      .cell_o     (cells[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  assign out_valid_o   = cells[0].valid;
  assign out_byte_o    = cells[0].data;
  assign is_attitude_o = cells[0].att;
  assign frame_end_o   = cells[0].last;

`ifndef SYNTHESIS
  // an empty head means no valid byte is held anywhere in the chain
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_vec[0] |-> valid_vec == '0)
    else $error("chain holds bytes behind an empty head");

  // a frame never breaks off before its checksum beat
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !frame_end_o |=> out_valid_o)
    else $error("frame interrupted before its last beat");

  // schedule slot stays in 1..9
  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q >= tfs_pkg::SlotFirst && slot_q <= tfs_pkg::SlotLast)
    else $error("schedule slot out of range");
`endif

endmodule

// File: sv/tfs_frame_build.sv
// Frame builder: lays out one attitude or position frame with its checksum.
// Depends on tfs_pkg.
module tfs_frame_build (
  input  logic                    att_i,
  input  logic signed [31:0]      latitude_i,
  input  logic signed [31:0]      longitude_i,
  input  logic        [7:0]       ground_speed_i,
  input  logic signed [31:0]      altitude_i,
  input  logic        [5:0]       satellite_count_i,
  input  logic        [1:0]       fix_kind_i,
  input  logic signed [15:0]      pitch_angle_i,
  input  logic signed [15:0]      roll_angle_i,
  input  logic        [15:0]      heading_angle_i,
  output tfs_pkg::cell_t          frame_o [tfs_pkg::FrameGLen]
);

  logic [7:0] pay [tfs_pkg::FrameGLen];
  logic [7:0] chk;

  // lay out header and payload, zero past the payload
  always_comb begin
    for (int k = 0; k < tfs_pkg::FrameGLen; k++) begin
      pay[k] = 8'h00;
    end
    pay[0] = tfs_pkg::SyncDollar;
    pay[1] = tfs_pkg::SyncT;
    if (att_i) begin
      pay[2] = tfs_pkg::IdAtt;
      pay[3] = pitch_angle_i[7:0];
      pay[4] = pitch_angle_i[15:8];
      pay[5] = roll_angle_i[7:0];
      pay[6] = roll_angle_i[15:8];
      pay[7] = heading_angle_i[7:0];
      pay[8] = heading_angle_i[15:8];
    end else begin
      pay[2]  = tfs_pkg::IdPos;
      pay[3]  = latitude_i[7:0];
      pay[4]  = latitude_i[15:8];
      pay[5]  = latitude_i[23:16];
      pay[6]  = latitude_i[31:24];
      pay[7]  = longitude_i[7:0];
      pay[8]  = longitude_i[15:8];
      pay[9]  = longitude_i[23:16];
      pay[10] = longitude_i[31:24];
      pay[11] = ground_speed_i;
      pay[12] = altitude_i[7:0];
      pay[13] = altitude_i[15:8];
      pay[14] = altitude_i[23:16];
      pay[15] = altitude_i[31:24];
      pay[16] = {satellite_count_i, fix_kind_i & tfs_pkg::FixMask};
    end
  end

  // checksum over payload bytes; zeros past the payload do not change it
  always_comb begin
    chk = 8'h00;
    for (int k = 3; k < tfs_pkg::FrameGLen - 1; k++) begin
      chk = chk ^ pay[k];
    end
  end

  // place checksum and mark valid and last bytes
  always_comb begin
    for (int k = 0; k < tfs_pkg::FrameGLen; k++) begin
      frame_o[k].att  = att_i;
      if (att_i) begin
        frame_o[k].valid = (k < tfs_pkg::FrameALen);
        frame_o[k].last  = (k == tfs_pkg::FrameALen - 1);
        frame_o[k].data  = (k == tfs_pkg::FrameALen - 1) ? chk : pay[k];
      end else begin
        frame_o[k].valid = 1'b1;
        frame_o[k].last  = (k == tfs_pkg::FrameGLen - 1);
        frame_o[k].data  = (k == tfs_pkg::FrameGLen - 1) ? chk : pay[k];
      end
    end
  end

endmodule

// File: sv/tfs_cell.sv
// One cell of the byte chain: loads a frame byte or takes its upstream neighbor.
// Depends on tfs_pkg.
module tfs_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  logic           load_i,
  input  tfs_pkg::cell_t load_val_i,
  input  tfs_pkg::cell_t nxt_i,
  output tfs_pkg::cell_t cell_o
);

  tfs_pkg::cell_t cell_d, cell_q;

  // load wins over shift, else hold
  always_comb begin
    cell_d = cell_q;
    if (load_i) begin
      cell_d = load_val_i;
    end else if (shift_i) begin
      cell_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
